/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define JSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/jsc_pkg.sv */
package jsc_pkg;

  // Stick count and accumulator storage.
  localparam int NUM_STICKS = 2;
  localparam int ACC_DEPTH  = 2 * NUM_STICKS;
  localparam int ACC_IDX_W  = $clog2(ACC_DEPTH);
  localparam int ACC_W      = 32;

  // Fixed-point constants (Q2.14 samples).
  localparam int ONE_Q14    = 16384;
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 15;
  localparam int NRM_SHIFT  = 30;
  localparam int ONE_SQ     = ONE_Q14 * ONE_Q14;

  // Shared multiplier.
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;

  // Accumulation scaling: |v| * sensitivity * frame_time, then shift by 24.
  localparam int SCALED_W   = 47;
  localparam int FRAC_SHIFT = 24;
  localparam int DELTA_W    = SCALED_W - FRAC_SHIFT + 2;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_IDX_W  = PADDR_W - 2;
  localparam int DZ_W       = 15;
  localparam int SENS_W     = 16;
  localparam int FT_W       = 16;

  localparam logic [REG_IDX_W-1:0] REG_DEAD_ZONE   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SENSITIVITY = 1'b1;
  localparam logic [SENS_W-1:0]    SENS_RESET      = 16'd256;

  // Bit masks of the normalization search.
  localparam logic [MAG_W-1:0] MASK_TOP  = MAG_W'(ONE_Q14);
  localparam logic [MAG_W-1:0] MASK_LAST = MAG_W'(1);

  typedef struct packed {
    logic [DZ_W-1:0]   dead_zone;
    logic [SENS_W-1:0] sensitivity;
  } jsc_cfg_t;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } jsc_mul_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_DZ,
    ST_SQ_CX,
    ST_SQ_CY,
    ST_CLAMP,
    ST_NRM_TX,
    ST_NRM_TY,
    ST_NRM_PX,
    ST_NRM_PY,
    ST_NRM_LAST,
    ST_ACC_MX,
    ST_ACC_FX,
    ST_ACC_MY,
    ST_ACC_FY,
    ST_ACC_DY,
    ST_ACC_WY,
    ST_DONE
  } jsc_state_t;

endpackage

/* sv/jsc_stream_if.sv */
// Sample channel: one raw stick reading per transfer.
interface jsc_in_if;
  logic               valid;
  logic               ready;
  logic               stick;
  logic signed [15:0] x_sample;
  logic signed [15:0] y_sample;
  logic [15:0]        frame_time;

  modport source (output valid, stick, x_sample, y_sample, frame_time, input ready);
  modport sink   (input valid, stick, x_sample, y_sample, frame_time, output ready);
endinterface

// Result channel: conditioned vector and updated accumulators per transfer.
interface jsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic               in_dead_zone;
  logic               was_normalized;

  modport source (output valid, out_x, out_y, acc_x, acc_y, in_dead_zone, was_normalized,
                  input ready);
  modport sink   (input valid, out_x, out_y, acc_x, acc_y, in_dead_zone, was_normalized,
                  output ready);
endinterface

/* sv/joystick_stick_conditioner.sv */
// Channel   Direction  Handshake             Payload
// samp      in         valid/ready           stick, x_sample, y_sample, frame_time
// result    out        valid/ready           out_x, out_y, acc_x, acc_y, flags
// apb       in         psel/penable/pready   dead_zone (0x0), sensitivity (0x4)
//
// An item goes through the squaring, clamp and accumulation states before the next ready,
// and the normalization search too when the clamped vector exceeds one; every product goes
// through the one registered 32x32 multiplier, which squares and scales each candidate.
// A finished result waits in the output register, so a new sample is taken meanwhile.
// Reset is synchronous and clears the accumulators, dead_zone (0) and sensitivity (256).
// A stalled result holds the block in its final state until the output register frees.
module joystick_stick_conditioner (
  input  logic                            clk,
  input  logic                            rst,
  jsc_in_if.sink                          samp,
  jsc_out_if.source                       result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jsc_pkg::PADDR_W-1:0]     paddr,
  input  logic [jsc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [jsc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import jsc_pkg::*;

  jsc_cfg_t          cfg;
  jsc_mul_op_t       mul_op;
  logic [PROD_W-1:0] prod;

  // Configuration registers.
  jsc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Shared multiplier.
  jsc_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  // Sequencer and datapath.
  jsc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .samp   (samp),
    .result (result),
    .cfg    (cfg),
    .mul_op (mul_op),
    .prod   (prod)
  );

endmodule

/* sv/jsc_cfg.sv */
module jsc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [jsc_pkg::PADDR_W-1:0]         paddr,
  input  logic [jsc_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [jsc_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output jsc_pkg::jsc_cfg_t                   cfg
);
  import jsc_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_sel;

  // Word-aligned register decode; a write lands in the access phase.
  assign reg_sel = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone   <= '0;
      cfg.sensitivity <= SENS_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DEAD_ZONE:   cfg.dead_zone   <= pwdata[DZ_W-1:0];
        REG_SENSITIVITY: cfg.sensitivity <= pwdata[SENS_W-1:0];
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_sel)
      REG_DEAD_ZONE:   prdata = CFG_DATA_W'(cfg.dead_zone);
      REG_SENSITIVITY: prdata = CFG_DATA_W'(cfg.sensitivity);
    endcase
  end

endmodule

/* sv/jsc_mul.sv */
module jsc_mul (
  input  logic                         clk,
  input  jsc_pkg::jsc_mul_op_t         op,
  output logic [jsc_pkg::PROD_W-1:0]   prod
);
  import jsc_pkg::*;

  // Unsigned 32x32 product, registered; the result is ready in the next cycle.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(op.a) * PROD_W'(op.b);
  end

endmodule

/* sv/jsc_core.sv */
module jsc_core (
  input  logic                         clk,
  input  logic                         rst,
  jsc_in_if.sink                       samp,
  jsc_out_if.source                    result,
  input  jsc_pkg::jsc_cfg_t            cfg,
  output jsc_pkg::jsc_mul_op_t         mul_op,
  input  logic [jsc_pkg::PROD_W-1:0]   prod
);
  import jsc_pkg::*;

  jsc_state_t state, state_next;

  // Latched sample.
  logic [SAMPLE_W-1:0]  mag_x, mag_y;
  logic                 sgn_x, sgn_y;
  logic [FT_W-1:0]      ft;
  logic [ACC_IDX_W-1:0] base_idx;

  // Squared lengths.
  logic [31:0]          len2;
  logic [29:0]          dz2;
  logic [28:0]          cx2, cy2;
  logic [29:0]          c2;
  logic                 dead, nrm;

  // Conditioned magnitudes; during normalization they hold the search result.
  logic [MAG_W-1:0]     vx_mag, vy_mag, ycand, mask;
  logic [MUL_W-1:0]     tsq;
  logic [DELTA_W-1:0]   delta;

  logic [ACC_W-1:0]     acc [ACC_DEPTH];
  logic [ACC_W-1:0]     res_acc_x, res_acc_y;

  // Combinational helpers.
  logic [SAMPLE_W-1:0]  in_mag_x, in_mag_y;
  logic [ACC_IDX_W-1:0] stick_sel, acc_idx;
  logic [MAG_W-1:0]     cmx, cmy, cand_x, cand_y;
  logic [MAG_W:0]       tx, ty;
  logic [29:0]          c2_sum;
  logic                 over_one;
  logic [PROD_W-1:0]    rhs_x, rhs_y;
  logic                 x_fits, y_fits;
  logic                 delta_neg;
  logic [SCALED_W-1:0]  scaled_rnd;
  logic [DELTA_W-1:0]   q_ext, delta_new;
  logic [ACC_W-1:0]     acc_rd, acc_sat;
  logic [ACC_W:0]       acc_sum;
  logic                 out_free;
  logic [SAMPLE_W-1:0]  vx16, vy16;

  // Magnitudes of the incoming sample; the most negative code maps to 32768.
  assign in_mag_x = samp.x_sample[SAMPLE_W-1] ? (~samp.x_sample + 16'd1) : samp.x_sample;
  assign in_mag_y = samp.y_sample[SAMPLE_W-1] ? (~samp.y_sample + 16'd1) : samp.y_sample;

  // An out-of-range stick index falls back to the last stick.
  assign stick_sel = (ACC_IDX_W'(samp.stick) >= ACC_IDX_W'(NUM_STICKS)) ?
                     ACC_IDX_W'(NUM_STICKS - 1) : ACC_IDX_W'(samp.stick);

  // Clamp each axis to one.
  assign cmx = (mag_x > SAMPLE_W'(ONE_Q14)) ? MAG_W'(ONE_Q14) : mag_x[MAG_W-1:0];
  assign cmy = (mag_y > SAMPLE_W'(ONE_Q14)) ? MAG_W'(ONE_Q14) : mag_y[MAG_W-1:0];

  assign c2_sum   = 30'(cx2) + 30'(prod[28:0]);
  assign over_one = c2_sum > 30'(ONE_SQ);

  // Normalization search: candidate t = 2*cand - 1, accepted when t^2 * c2 <= mag^2 * 2^30.
  assign cand_x = vx_mag | mask;
  assign cand_y = vy_mag | mask;
  assign tx     = {cand_x, 1'b0} - (MAG_W+1)'(1);
  assign ty     = {cand_y, 1'b0} - (MAG_W+1)'(1);
  assign rhs_x  = PROD_W'(cx2) << NRM_SHIFT;
  assign rhs_y  = PROD_W'(cy2) << NRM_SHIFT;
  assign x_fits = prod <= rhs_x;
  assign y_fits = prod <= rhs_y;

  // Scaled increment, floor of the signed product over 2^24.
  assign delta_neg  = (state == ST_ACC_MY) ? sgn_x : sgn_y;
  assign scaled_rnd = prod[SCALED_W-1:0] +
                      (delta_neg ? SCALED_W'((1 << FRAC_SHIFT) - 1) : SCALED_W'(0));
  assign q_ext      = DELTA_W'(scaled_rnd[SCALED_W-1:FRAC_SHIFT]);
  assign delta_new  = delta_neg ? (~q_ext + DELTA_W'(1)) : q_ext;

  // Saturating accumulator update; one accumulator is read per cycle.
  assign acc_idx = (state == ST_ACC_WY) ? (base_idx | ACC_IDX_W'(1)) : base_idx;
  assign acc_rd  = acc[acc_idx];
  assign acc_sum = {acc_rd[ACC_W-1], acc_rd} +
                   {{(ACC_W + 1 - DELTA_W){delta[DELTA_W-1]}}, delta};
  assign acc_sat = (acc_sum[ACC_W] != acc_sum[ACC_W-1]) ?
                   (acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}}) :
                   acc_sum[ACC_W-1:0];

  assign out_free = !result.valid || result.ready;
  assign vx16     = SAMPLE_W'(vx_mag);
  assign vy16     = SAMPLE_W'(vy_mag);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (samp.valid) state_next = ST_SQ_X;
      ST_SQ_X:     state_next = ST_SQ_Y;
      ST_SQ_Y:     state_next = ST_SQ_DZ;
      ST_SQ_DZ:    state_next = ST_SQ_CX;
      ST_SQ_CX:    state_next = ST_SQ_CY;
      ST_SQ_CY:    state_next = ST_CLAMP;
      ST_CLAMP:    state_next = (!dead && over_one) ? ST_NRM_TX : ST_ACC_MX;
      ST_NRM_TX:   state_next = ST_NRM_TY;
      ST_NRM_TY:   state_next = ST_NRM_PX;
      ST_NRM_PX:   state_next = ST_NRM_PY;
      ST_NRM_PY:   state_next = (mask == MASK_LAST) ? ST_NRM_LAST : ST_NRM_TX;
      ST_NRM_LAST: state_next = ST_ACC_MX;
      ST_ACC_MX:   state_next = ST_ACC_FX;
      ST_ACC_FX:   state_next = ST_ACC_MY;
      ST_ACC_MY:   state_next = ST_ACC_FY;
      ST_ACC_FY:   state_next = ST_ACC_DY;
      ST_ACC_DY:   state_next = ST_ACC_WY;
      ST_ACC_WY:   state_next = ST_DONE;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Multiplier operands and the input handshake.
  always_comb begin
    mul_op     = '0;
    samp.ready = 1'b0;
    unique case (state)
      ST_IDLE:   samp.ready = 1'b1;
      ST_SQ_X:   begin mul_op.a = MUL_W'(mag_x);         mul_op.b = MUL_W'(mag_x); end
      ST_SQ_Y:   begin mul_op.a = MUL_W'(mag_y);         mul_op.b = MUL_W'(mag_y); end
      ST_SQ_DZ:  begin
        mul_op.a = MUL_W'(cfg.dead_zone);
        mul_op.b = MUL_W'(cfg.dead_zone);
      end
      ST_SQ_CX:  begin mul_op.a = MUL_W'(cmx);           mul_op.b = MUL_W'(cmx); end
      ST_SQ_CY:  begin mul_op.a = MUL_W'(cmy);           mul_op.b = MUL_W'(cmy); end
      ST_NRM_TX: begin mul_op.a = MUL_W'(tx);            mul_op.b = MUL_W'(tx); end
      ST_NRM_TY: begin mul_op.a = MUL_W'(ty);            mul_op.b = MUL_W'(ty); end
      ST_NRM_PX: begin mul_op.a = tsq;                   mul_op.b = MUL_W'(c2); end
      ST_NRM_PY: begin mul_op.a = tsq;                   mul_op.b = MUL_W'(c2); end
      ST_ACC_MX: begin
        mul_op.a = MUL_W'(vx_mag);
        mul_op.b = MUL_W'(cfg.sensitivity);
      end
      ST_ACC_FX: begin mul_op.a = MUL_W'(prod[30:0]);    mul_op.b = MUL_W'(ft); end
      ST_ACC_MY: begin
        mul_op.a = MUL_W'(vy_mag);
        mul_op.b = MUL_W'(cfg.sensitivity);
      end
      ST_ACC_FY: begin mul_op.a = MUL_W'(prod[30:0]);    mul_op.b = MUL_W'(ft); end
      default:   mul_op = '0;
    endcase
  end

  // Control state, accumulators and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
      for (int i = 0; i < ACC_DEPTH; i++) begin
        acc[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_ACC_FY || state == ST_ACC_WY) begin
        acc[acc_idx] <= acc_sat;
      end
      if (state == ST_DONE && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Datapath registers, one step per state.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        mag_x    <= in_mag_x;
        mag_y    <= in_mag_y;
        sgn_x    <= samp.x_sample[SAMPLE_W-1];
        sgn_y    <= samp.y_sample[SAMPLE_W-1];
        ft       <= samp.frame_time;
        base_idx <= stick_sel << 1;
      end
      ST_SQ_Y:  len2 <= prod[31:0];
      ST_SQ_DZ: len2 <= len2 + prod[31:0];
      ST_SQ_CX: dz2  <= prod[29:0];
      ST_SQ_CY: begin
        cx2  <= prod[28:0];
        dead <= len2 < 32'(dz2);
      end
      ST_CLAMP: begin
        cy2  <= prod[28:0];
        c2   <= c2_sum;
        nrm  <= !dead && over_one;
        mask <= MASK_TOP;
        if (dead || over_one) begin
          vx_mag <= '0;
          vy_mag <= '0;
        end else begin
          vx_mag <= cmx;
          vy_mag <= cmy;
        end
      end
      // The y decision of the previous bit arrives while x starts the next one.
      ST_NRM_TX: if (mask != MASK_TOP && y_fits) vy_mag <= ycand;
      ST_NRM_TY: begin
        tsq   <= prod[MUL_W-1:0];
        ycand <= cand_y;
      end
      ST_NRM_PX: tsq <= prod[MUL_W-1:0];
      ST_NRM_PY: begin
        if (x_fits) vx_mag <= cand_x;
        mask <= mask >> 1;
      end
      ST_NRM_LAST: if (y_fits) vy_mag <= ycand;
      ST_ACC_MY:   delta <= delta_new;
      ST_ACC_FY:   res_acc_x <= acc_sat;
      ST_ACC_DY:   delta <= delta_new;
      ST_ACC_WY:   res_acc_y <= acc_sat;
      ST_DONE: begin
        if (out_free) begin
          result.out_x          <= sgn_x ? (~vx16 + 16'd1) : vx16;
          result.out_y          <= sgn_y ? (~vy16 + 16'd1) : vy16;
          result.acc_x          <= res_acc_x;
          result.acc_y          <= res_acc_y;
          result.in_dead_zone   <= dead;
          result.was_normalized <= nrm;
        end
      end
      default: ;
    endcase
  end

endmodule

/* sv/jsc_checker.sv */
`include "assert_macros.svh"

module jsc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic               in_dead_zone,
  input logic               was_normalized
);

  // A pending result stays offered until its transfer.
  `JSC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")

  // One sample at a time: the block is busy right after taking one.
  `JSC_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready, "not busy")

  // A zeroed sample is never also rescaled.
  `JSC_ASSERT_IMPL(a_flags_apart, clk, rst, out_valid, !(in_dead_zone && was_normalized), "flags")

  // A dead-zone result carries a zero vector.
  `JSC_ASSERT_IMPL(a_dead_zero, clk, rst, out_valid && in_dead_zone, (out_x == 16'sd0) && (out_y == 16'sd0), "dead zone vector")

endmodule

bind joystick_stick_conditioner jsc_checker u_jsc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samp.valid),
  .in_ready       (samp.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .out_x          (result.out_x),
  .out_y          (result.out_y),
  .in_dead_zone   (result.in_dead_zone),
  .was_normalized (result.was_normalized)
);
